// File: src/rps_pkg.sv
// Shared types, constants and byte functions for the radio payload scrambler.
package rps_pkg;

    localparam int unsigned NumBytes = 8;
    localparam logic [7:0] OffsetStart = 8'hFE;
    localparam logic [7:0] OffsetStep = 8'h22;
    localparam logic [15:0] CountMult = 16'h708F;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [63:0] block_in;
        logic [15:0] key;
        logic [7:0]  packet_count;
    } rps_in_t;

    typedef struct packed {
        logic [63:0] block_out;
        logic [7:0]  expected_parity;
        logic        parity_ok;
    } rps_out_t;

    typedef struct packed {
        logic        op;
        logic [63:0] block;
        logic [15:0] key;
        logic [15:0] num;
    } rps_s1_t;

    typedef struct packed {
        logic        op;
        logic [63:0] block;
        logic [15:0] num;
    } rps_s2_t;

    typedef struct packed {
        logic v1;
        logic v2;
        logic v3;
    } rps_occ_t;

    function automatic logic [3:0] sbox_fwd(input logic [3:0] v);
        logic [3:0] r;
        unique case (v)
            4'h0: r = 4'h8;
            4'h1: r = 4'h2;
            4'h2: r = 4'hd;
            4'h3: r = 4'h1;
            4'h4: r = 4'hf;
            4'h5: r = 4'he;
            4'h6: r = 4'h7;
            4'h7: r = 4'h5;
            4'h8: r = 4'h9;
            4'h9: r = 4'hc;
            4'ha: r = 4'h0;
            4'hb: r = 4'ha;
            4'hc: r = 4'h3;
            4'hd: r = 4'h4;
            4'he: r = 4'hb;
            default: r = 4'h6;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] sbox_inv(input logic [3:0] v);
        logic [3:0] r;
        unique case (v)
            4'h0: r = 4'ha;
            4'h1: r = 4'h3;
            4'h2: r = 4'h1;
            4'h3: r = 4'hc;
            4'h4: r = 4'hd;
            4'h5: r = 4'h7;
            4'h6: r = 4'hf;
            4'h7: r = 4'h6;
            4'h8: r = 4'h0;
            4'h9: r = 4'h8;
            4'ha: r = 4'hb;
            4'hb: r = 4'he;
            4'hc: r = 4'h9;
            4'hd: r = 4'h2;
            4'he: r = 4'h5;
            default: r = 4'h4;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] byte_offset(input logic [2:0] idx);
        return 8'(OffsetStart - 8'(OffsetStep * {5'd0, idx}));
    endfunction

    function automatic logic [7:0] nib_add(input logic [7:0] d, input logic [7:0] r);
        return {4'(d[7:4] + r[7:4]), 4'(d[3:0] + r[3:0])};
    endfunction

    function automatic logic [7:0] nib_sub(input logic [7:0] d, input logic [7:0] r);
        return {4'(d[7:4] - r[7:4]), 4'(d[3:0] - r[3:0])};
    endfunction

    // Bit 7-k is the parity of bytes 2k and 2k+1 together; the low nibble is zero.
    function automatic logic [7:0] pair_parity(input logic [63:0] blk);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 4; k++)
        begin
            p[7 - k] = ^blk[63 - 16 * k -: 16];
        end
        return p;
    endfunction

endpackage

// File: src/rps_front.sv
// First stage: parity and offset add on encode; on decode, inverse substitution and offset removal on bytes 0 and 1.
module rps_front
    import rps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  rps_in_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output rps_s1_t out_data
);

    logic    valid_reg;
    rps_s1_t data_reg;
    rps_s1_t data_next;

    logic [63:0] enc_blk;
    logic [63:0] dec_blk;
    logic [63:0] par_blk;
    logic [15:0] prod;

    always_comb
    begin
        par_blk = in_data.block_in;
        par_blk[7:0] = pair_parity(in_data.block_in);
        for (int i = 0; i < NumBytes; i++)
        begin
            enc_blk[63 - 8 * i -: 8] = nib_add(par_blk[63 - 8 * i -: 8], byte_offset(3'(i)));
        end
        for (int n = 0; n < 2 * NumBytes; n++)
        begin
            dec_blk[4 * n +: 4] = sbox_inv(in_data.block_in[4 * n +: 4]);
        end
        dec_blk[63:56] = nib_sub(dec_blk[63:56], byte_offset(3'd0));
        dec_blk[55:48] = nib_sub(dec_blk[55:48], byte_offset(3'd1));
        prod = 16'({8'd0, in_data.packet_count} * CountMult);
    end

    always_comb
    begin
        data_next.op = in_data.op;
        data_next.key = in_data.key;
        data_next.num = 16'(16'd0 - prod);
        data_next.block = (in_data.op == OP_DECODE) ? dec_blk : enc_blk;
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: src/rps_mix.sv
// Second stage: key XOR, and on decode key extraction and offset removal.
module rps_mix
    import rps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  rps_s1_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output rps_s2_t out_data
);

    logic    valid_reg;
    rps_s2_t data_reg;
    rps_s2_t data_next;

    logic [63:0] enc_blk;
    logic [63:0] dec_blk;
    logic [15:0] dkey;

    always_comb
    begin
        dkey = in_data.block[63:48];
        enc_blk = in_data.block;
        dec_blk = in_data.block;
        for (int i = 1; i < NumBytes / 2; i++)
        begin
            enc_blk[63 - 16 * i -: 16] = in_data.block[63 - 16 * i -: 16] ^ in_data.key;
        end
        dec_blk[63:48] = 16'h0000;
        for (int i = 2; i < NumBytes; i++)
        begin
            dec_blk[63 - 8 * i -: 8] = nib_sub(
                in_data.block[63 - 8 * i -: 8] ^ ((i % 2 == 0) ? dkey[15:8] : dkey[7:0]),
                byte_offset(3'(i)));
        end
    end

    always_comb
    begin
        data_next.op = in_data.op;
        data_next.num = in_data.num;
        data_next.block = (in_data.op == OP_DECODE) ? dec_blk : enc_blk;
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: src/rps_back.sv
// Third stage: forward substitution on encode, parity check on decode.
module rps_back
    import rps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rps_s2_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output rps_out_t out_data
);

    logic     valid_reg;
    rps_out_t data_reg;
    rps_out_t data_next;

    logic [63:0] enc_blk;
    logic [63:0] chk_blk;
    logic [7:0]  expect_par;

    always_comb
    begin
        for (int n = 0; n < 2 * NumBytes; n++)
        begin
            enc_blk[4 * n +: 4] = sbox_fwd(in_data.block[4 * n +: 4]);
        end
        chk_blk = {in_data.num, in_data.block[47:8], 8'h00};
        expect_par = pair_parity(chk_blk);
    end

    always_comb
    begin
        if (in_data.op == OP_DECODE)
        begin
            data_next.block_out = in_data.block;
            data_next.expected_parity = expect_par;
            data_next.parity_ok = (in_data.block[7:0] == expect_par);
        end
        else
        begin
            data_next.block_out = enc_blk;
            data_next.expected_parity = 8'h00;
            data_next.parity_ok = 1'b0;
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: src/radio_payload_scrambler.sv
// Top level of the radio payload scrambler: three-stage encode/decode pipeline.
//
// The input channel (in_valid, in_ready, in_data) carries one 8-byte block per
// beat with its operation, encode key and packet counter. The output channel
// (out_valid, out_ready, out_data) returns one beat per input beat, in order,
// with the processed block, and on decode the expected parity and match flag.
// Encode results carry zero in both parity fields.
// Throughput is one beat per cycle while the receiver does not stall; every
// stage holds one beat, so up to three are in flight. The three register
// stages are parity and offset (or inverse substitution), key mixing, then
// substitution (or parity check); each beat passes them in that order.
// Reset clears all stage valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, the output register holds its beat and earlier
// stages keep filling until full, after which in_ready drops.
module radio_payload_scrambler
    import rps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rps_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output rps_out_t out_data
);

    logic     s1_valid;
    logic     s1_ready;
    rps_s1_t  s1_data;
    logic     s2_valid;
    logic     s2_ready;
    rps_s2_t  s2_data;
    rps_occ_t occ;

    rps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    rps_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    rps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign occ = '{v1: s1_valid, v2: s2_valid, v3: out_valid};

    // Input back-pressure only appears when every stage holds a beat.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (occ.v1 && occ.v2 && occ.v3))
        else $error("input stalled while pipeline has a free stage");

    a_stage1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_data)))
        else $error("first stage beat lost during stall");

    a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.parity_ok) |->
            (out_data.block_out[7:0] == out_data.expected_parity))
        else $error("parity flag disagrees with block");

    a_parity_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.expected_parity[3:0] == 4'h0))
        else $error("expected parity has low nibble set");

endmodule
